[rtl/m3i_pkg.sv]
// Shared widths and beat types for the 3x3 matrix inverse pipeline.
package m3i_pkg;

    localparam int EW = 32;              // element width
    localparam int FB = 16;              // fractional bits
    localparam int PW = 2 * EW;          // element product
    localparam int CW = PW + 1;          // cofactor
    localparam int TW = EW + CW;         // element times cofactor
    localparam int DW = TW + 2;          // determinant
    localparam int NW = DW + 1;          // divider numerator / divisor
    localparam int XW = NW + EW + 1;     // divider compare width

    typedef logic signed [EW-1:0] t_elem;
    typedef logic [8:0][EW-1:0]   t_elem_vec;
    typedef logic [2:0][EW-1:0]   t_row_vec;
    typedef logic [8:0][CW-1:0]   t_cof_vec;

    typedef struct packed {
        t_elem a00; t_elem a01; t_elem a02;
        t_elem a10; t_elem a11; t_elem a12;
        t_elem a20; t_elem a21; t_elem a22;
    } t_in_beat;

    typedef struct packed {
        t_elem b00; t_elem b01; t_elem b02;
        t_elem b10; t_elem b11; t_elem b12;
        t_elem b20; t_elem b21; t_elem b22;
        logic  singular;
        logic  overflow;
    } t_out_beat;

endpackage

[rtl/m3i_cofactor.sv]
// Cofactor stages: element products, then the nine 2x2 differences.
module m3i_cofactor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  m3i_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output m3i_pkg::t_cof_vec o_cof,
    output m3i_pkg::t_row_vec o_row
);
    import m3i_pkg::*;

    localparam int unsigned IX1 [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned IY1 [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned IX2 [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned IY2 [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    t_elem a [9];
    logic signed [PW-1:0] n_p1 [9], n_p2 [9], r_p1 [9], r_p2 [9];
    logic signed [CW-1:0] n_cof [9], r_cof [9];
    t_row_vec r_row1, r_row2;
    logic r_v1, r_v2, w_en1, w_en2;

    assign a[0] = i_data.a00; assign a[1] = i_data.a01; assign a[2] = i_data.a02;
    assign a[3] = i_data.a10; assign a[4] = i_data.a11; assign a[5] = i_data.a12;
    assign a[6] = i_data.a20; assign a[7] = i_data.a21; assign a[8] = i_data.a22;

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v2;
    assign o_row   = r_row2;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_p1[i]  = a[IX1[i]] * a[IY1[i]];
            n_p2[i]  = a[IX2[i]] * a[IY2[i]];
            n_cof[i] = CW'(r_p1[i]) - CW'(r_p2[i]);
            o_cof[i] = r_cof[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_row1 <= {a[2], a[1], a[0]};
        end
        if (w_en2) begin
            r_cof  <= n_cof;
            r_row2 <= r_row1;
        end
    end

endmodule

[rtl/m3i_det.sv]
// Determinant stages: split partial products, term assembly, three-term sum.
module m3i_det (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  m3i_pkg::t_cof_vec i_cof,
    input  m3i_pkg::t_row_vec i_row,
    output logic              o_valid,
    input  logic              i_ready,
    output m3i_pkg::t_cof_vec o_cof,
    output logic [m3i_pkg::DW-1:0] o_det
);
    import m3i_pkg::*;

    localparam int unsigned CJ [3] = '{0, 3, 6};

    logic signed [2*EW:0] n_pl [3], n_ph [3], r_pl [3], r_ph [3];
    logic signed [TW-1:0] n_t [3], r_t [3];
    logic signed [DW-1:0] n_det, r_det;
    t_cof_vec r_cofa, r_cofb, r_cofc;
    logic r_va, r_vb, r_vc, w_ena, w_enb, w_enc;

    assign w_enc   = !r_vc || i_ready;
    assign w_enb   = !r_vb || w_enc;
    assign w_ena   = !r_va || w_enb;
    assign o_ready = w_ena;
    assign o_valid = r_vc;
    assign o_cof   = r_cofc;
    assign o_det   = r_det;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            // cofactor split: unsigned low word, signed high part
            n_pl[j] = $signed(i_row[j]) * $signed({1'b0, i_cof[CJ[j]][EW-1:0]});
            n_ph[j] = $signed(i_row[j]) * $signed(i_cof[CJ[j]][CW-1:EW]);
            n_t[j]  = (TW'(r_ph[j]) <<< EW) + TW'(r_pl[j]);
        end
        n_det = DW'(r_t[0]) + DW'(r_t[1]) + DW'(r_t[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_ena) r_va <= i_valid;
            if (w_enb) r_vb <= r_va;
            if (w_enc) r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ena) begin
            r_pl   <= n_pl;
            r_ph   <= n_ph;
            r_cofa <= i_cof;
        end
        if (w_enb) begin
            r_t    <= n_t;
            r_cofb <= r_cofa;
        end
        if (w_enc) begin
            r_det  <= n_det;
            r_cofc <= r_cofb;
        end
    end

endmodule

[rtl/m3i_div.sv]
// Nine-lane pipelined restoring divider with rounding setup and saturation.
module m3i_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  m3i_pkg::t_cof_vec      i_absc,
    input  logic [m3i_pkg::DW-1:0] i_absd,
    input  logic [8:0]             i_neg,
    input  logic                   i_zero,
    output logic                   o_valid,
    input  logic                   i_ready,
    output m3i_pkg::t_elem_vec     o_elem,
    output logic                   o_singular,
    output logic                   o_overflow
);
    import m3i_pkg::*;

    localparam logic [EW-1:0] LIM  = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] NMIN = {1'b1, {(EW-1){1'b0}}};

    // stage 0 is setup, stage s in 1..EW resolves quotient bit EW-s
    // remainder and divisor are not needed past the last quotient bit
    logic [NW-1:0] r_rem [EW][9];
    logic [NW-1:0] r_d   [EW][9];
    logic [EW-1:0] r_q   [EW+1][9];
    logic          r_neg [EW+1][9];
    logic          r_big [EW+1][9];
    logic          r_zero [EW+1];
    logic          r_v   [EW+1];
    logic [EW+1:0] w_en;

    t_elem_vec     n_elem, r_elem;
    logic          n_ovf, r_ovf, r_sing, r_vo;

    assign w_en[EW+1] = !r_vo || i_ready;
    for (genvar s = 0; s <= EW; s++) begin : g_en
        assign w_en[s] = !r_v[s] || w_en[s+1];
    end
    assign o_ready    = w_en[0];
    assign o_valid    = r_vo;
    assign o_elem     = r_elem;
    assign o_singular = r_sing;
    assign o_overflow = r_ovf;

    // setup: n = 2|C|*2^(2F) + |D|, d = 2|D|; quotient too large when n >= d*2^EW
    for (genvar l = 0; l < 9; l++) begin : g_setup
        logic [NW-1:0] w_n, w_d;
        assign w_n = (NW'(i_absc[l]) << (2 * FB + 1)) + NW'(i_absd);
        assign w_d = NW'(i_absd) << 1;
        always_ff @(posedge i_clk) begin
            if (w_en[0]) begin
                r_rem[0][l] <= w_n;
                r_d[0][l]   <= w_d;
                r_q[0][l]   <= '0;
                r_neg[0][l] <= i_neg[l];
                r_big[0][l] <= XW'(w_n) >= (XW'(w_d) << EW);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_zero[0] <= i_zero;
    end

    for (genvar s = 1; s <= EW; s++) begin : g_stage
        localparam int K = EW - s;
        for (genvar l = 0; l < 9; l++) begin : g_lane
            logic [XW-1:0] w_dk;
            logic          w_ge;
            logic [EW-1:0] w_q;
            assign w_dk = XW'(r_d[s-1][l]) << K;
            assign w_ge = XW'(r_rem[s-1][l]) >= w_dk;
            always_comb begin
                w_q    = r_q[s-1][l];
                w_q[K] = w_ge;
            end
            always_ff @(posedge i_clk) begin
                if (w_en[s]) begin
                    r_q[s][l]   <= w_q;
                    r_neg[s][l] <= r_neg[s-1][l];
                    r_big[s][l] <= r_big[s-1][l];
                end
            end
            if (s < EW) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (w_en[s]) begin
                        r_rem[s][l] <= w_ge ? NW'(XW'(r_rem[s-1][l]) - w_dk)
                                            : r_rem[s-1][l];
                        r_d[s][l]   <= r_d[s-1][l];
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en[s]) r_zero[s] <= r_zero[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= EW; s++) r_v[s] <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int s = 1; s <= EW; s++) begin
                if (w_en[s]) r_v[s] <= r_v[s-1];
            end
            if (w_en[EW+1]) r_vo <= r_v[EW];
        end
    end

    // rounding is folded into n; here only sign, saturation and the singular zero remain
    always_comb begin
        n_ovf = 1'b0;
        for (int l = 0; l < 9; l++) begin
            if (r_zero[EW]) begin
                n_elem[l] = '0;
            end else if (!r_neg[EW][l]) begin
                if (r_big[EW][l] || r_q[EW][l] > LIM) begin
                    n_elem[l] = LIM;
                    n_ovf     = 1'b1;
                end else begin
                    n_elem[l] = r_q[EW][l];
                end
            end else begin
                if (r_big[EW][l] || r_q[EW][l] > NMIN) begin
                    n_elem[l] = NMIN;
                    n_ovf     = 1'b1;
                end else begin
                    n_elem[l] = ~r_q[EW][l] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[EW+1]) begin
            r_elem <= n_elem;
            r_ovf  <= n_ovf;
            r_sing <= r_zero[EW];
        end
    end

endmodule

[rtl/matrix3x3_inverse_unit.sv]
// Top level: 3x3 matrix inverse by adjugate over determinant, fully pipelined.
// Usage:
//   Input channel i_valid / o_ready carries one matrix per beat in i_data,
//   nine signed Q16.16 elements by row. Output channel o_valid / i_ready
//   carries the inverse in o_data (b00..b22 by row) with two flags:
//   singular (determinant exactly zero, all elements zero) and overflow
//   (one or more elements saturated to the 32-bit signed range).
//   Each output element is the cofactor over the determinant, rounded to
//   nearest with ties away from zero.
// Timing:
//   The pipeline has 40 registered stages: products and cofactors, the
//   split determinant products and sum, magnitudes and signs, the divider
//   setup, the divider (one quotient bit per stage across nine lanes), and
//   the saturating output register, in that order.
//   Throughput is one matrix per cycle while i_ready is high; a low
//   i_ready stalls the pipeline as described below.
// Reset and stall:
//   Synchronous active-low reset empties every stage; data registers are
//   not cleared. When i_ready is low the output holds its beat and empty
//   stages upstream keep filling, so o_ready stays high until every stage
//   holds a beat. No beat is dropped or duplicated.
module matrix3x3_inverse_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  m3i_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output m3i_pkg::t_out_beat o_data
);
    import m3i_pkg::*;

    logic          w_cf_valid, w_cf_ready;
    t_cof_vec      w_cf_cof;
    t_row_vec      w_cf_row;

    logic          w_dt_valid, w_dt_ready;
    t_cof_vec      w_dt_cof;
    logic [DW-1:0] w_dt_det;

    // magnitude / sign stage
    t_cof_vec      n_absc, r_absc;
    logic [DW-1:0] n_absd, r_absd;
    logic [8:0]    n_neg, r_neg;
    logic          r_zero, r_vp, w_enp, w_dv_ready;

    t_elem_vec     w_elem;
    logic          w_sing, w_ovf;

    m3i_cofactor u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (w_cf_valid),
        .i_ready (w_cf_ready),
        .o_cof   (w_cf_cof),
        .o_row   (w_cf_row)
    );

    m3i_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cf_valid),
        .o_ready (w_cf_ready),
        .i_cof   (w_cf_cof),
        .i_row   (w_cf_row),
        .o_valid (w_dt_valid),
        .i_ready (w_dt_ready),
        .o_cof   (w_dt_cof),
        .o_det   (w_dt_det)
    );

    assign w_enp      = !r_vp || w_dv_ready;
    assign w_dt_ready = w_enp;

    always_comb begin
        n_absd = w_dt_det[DW-1] ? (~w_dt_det + 1'b1) : w_dt_det;
        for (int i = 0; i < 9; i++) begin
            n_absc[i] = w_dt_cof[i][CW-1] ? (~w_dt_cof[i] + 1'b1) : w_dt_cof[i];
            n_neg[i]  = w_dt_cof[i][CW-1] ^ w_dt_det[DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (w_enp) begin
            r_vp <= w_dt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enp) begin
            r_absc <= n_absc;
            r_absd <= n_absd;
            r_neg  <= n_neg;
            r_zero <= (w_dt_det == '0);
        end
    end

    m3i_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_vp),
        .o_ready    (w_dv_ready),
        .i_absc     (r_absc),
        .i_absd     (r_absd),
        .i_neg      (r_neg),
        .i_zero     (r_zero),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_elem     (w_elem),
        .o_singular (w_sing),
        .o_overflow (w_ovf)
    );

    assign o_data.b00      = w_elem[0];
    assign o_data.b01      = w_elem[1];
    assign o_data.b02      = w_elem[2];
    assign o_data.b10      = w_elem[3];
    assign o_data.b11      = w_elem[4];
    assign o_data.b12      = w_elem[5];
    assign o_data.b20      = w_elem[6];
    assign o_data.b21      = w_elem[7];
    assign o_data.b22      = w_elem[8];
    assign o_data.singular = w_sing;
    assign o_data.overflow = w_ovf;

endmodule
